@@ rtl/http_chunked_encoder_defines.svh @@
// Assertion macros used by the checker file.
`ifndef HTTP_CHUNKED_ENCODER_DEFINES_SVH
`define HTTP_CHUNKED_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hce check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hce check failed");

`endif

@@ rtl/hce_pkg.sv @@
// Shared types, constants and helpers for the chunked transfer encoder.
`default_nettype none
package hce_pkg;

  localparam int MAX_CHUNK_BYTES_DEF = 32;
  localparam logic [5:0] LIMIT_RESET = 6'd32;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [2:0] {
    SEL_HEXH,
    SEL_HEXL,
    SEL_CR,
    SEL_LF,
    SEL_DATA,
    SEL_ZERO
  } sel_t;

  typedef struct packed {
    logic append;
    logic load;
    sel_t sel;
    logic last;
    logic rd_adv;
    logic rd_clear;
    logic fill_clear;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic fill_ge_lim;
    logic fill_nz;
    logic fill_ge16;
    logic data_last;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h57 + {4'h0, v};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hce_datapath.sv @@
// Datapath: chunk buffer, fill count, limit register and output register.
`default_nettype none
module hce_datapath #(
  parameter int MAX_CHUNK_BYTES = hce_pkg::MAX_CHUNK_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [5:0]     cfg_wdata,
  input  wire logic [7:0]     in_data,
  input  wire logic           in_byte_valid,
  input  wire hce_pkg::cmd_t  cmd,
  output hce_pkg::status_t    status,
  output logic                out_tvalid,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  input  wire logic           out_tready
);

  localparam int CW = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int AW = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;

  logic [7:0]    mem [MAX_CHUNK_BYTES];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [5:0]    cfg_r;
  logic [5:0]    lim;
  logic [5:0]    fill6;
  logic [7:0]    fill8;
  logic          full;
  logic          wr_en;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_byte;
  logic          out_last_r;

  assign full  = (fill_r == CW'(MAX_CHUNK_BYTES));
  assign wr_en = cmd.append && in_byte_valid && !full;
  assign fill6 = 6'(fill_r);
  assign fill8 = 8'(fill_r);

  always_comb begin
    if (cfg_r == 6'd0) begin
      lim = 6'd1;
    end else if (cfg_r > 6'(MAX_CHUNK_BYTES)) begin
      lim = 6'(MAX_CHUNK_BYTES);
    end else begin
      lim = cfg_r;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_clear) begin
      fill_nxt = '0;
    end else if (wr_en) begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.rd_clear) begin
      rd_ptr_nxt = '0;
    end else if (cmd.rd_adv) begin
      rd_ptr_nxt = rd_ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= hce_pkg::LIMIT_RESET;
      fill_r   <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      fill_r   <= fill_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_ptr_nxt];
  end

  always_comb begin
    unique case (cmd.sel)
      hce_pkg::SEL_HEXH: out_byte = hce_pkg::hex_char(fill8[7:4]);
      hce_pkg::SEL_HEXL: out_byte = hce_pkg::hex_char(fill8[3:0]);
      hce_pkg::SEL_CR:   out_byte = hce_pkg::CH_CR;
      hce_pkg::SEL_LF:   out_byte = hce_pkg::CH_LF;
      hce_pkg::SEL_DATA: out_byte = rd_q;
      hce_pkg::SEL_ZERO: out_byte = hce_pkg::CH_ZERO;
      default:           out_byte = hce_pkg::CH_ZERO;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= out_byte;
      out_last_r <= cmd.last;
    end
  end

  assign status.slot_free   = !out_valid_r || out_tready;
  assign status.fill_ge_lim = (fill6 >= lim);
  assign status.fill_nz     = (fill_r != '0);
  assign status.fill_ge16   = (fill8 >= 8'd16);
  assign status.data_last   = ((CW'(rd_ptr_r) + CW'(1)) == fill_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

@@ rtl/hce_ctrl.sv @@
// Controller: sequences chunk framing and the last chunk, one request at a time.
`default_nettype none
module hce_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_byte_valid,
  input  wire logic             in_batch_end,
  input  wire logic             in_stream_end,
  input  wire hce_pkg::status_t status,
  output hce_pkg::cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_HEXH   = 4'd2;
  localparam logic [3:0] S_HEXL   = 4'd3;
  localparam logic [3:0] S_CR1    = 4'd4;
  localparam logic [3:0] S_LF1    = 4'd5;
  localparam logic [3:0] S_DATA   = 4'd6;
  localparam logic [3:0] S_CR2    = 4'd7;
  localparam logic [3:0] S_LF2    = 4'd8;
  localparam logic [3:0] S_Z0     = 4'd9;
  localparam logic [3:0] S_ZCR1   = 4'd10;
  localparam logic [3:0] S_ZLF1   = 4'd11;
  localparam logic [3:0] S_ZCR2   = 4'd12;
  localparam logic [3:0] S_ZLF2   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       valid_r, end_r, strm_r;
  logic       accept;
  logic       chunk;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign chunk     = (valid_r && status.fill_ge_lim) || (end_r && status.fill_nz);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.sel        = hce_pkg::SEL_CR;
    cmd.append     = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (chunk) begin
          state_nxt = status.fill_ge16 ? S_HEXH : S_HEXL;
        end else if (strm_r) begin
          state_nxt = S_Z0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HEXH: begin
        cmd.sel = hce_pkg::SEL_HEXH;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_HEXL;
        end
      end
      S_HEXL: begin
        cmd.sel = hce_pkg::SEL_HEXL;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_CR1;
        end
      end
      S_CR1: begin
        cmd.sel = hce_pkg::SEL_CR;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_LF1;
        end
      end
      S_LF1: begin
        cmd.sel = hce_pkg::SEL_LF;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        cmd.sel = hce_pkg::SEL_DATA;
        if (status.slot_free) begin
          cmd.load = 1'b1;
          if (status.data_last) begin
            cmd.rd_clear = 1'b1;
            state_nxt    = S_CR2;
          end else begin
            cmd.rd_adv = 1'b1;
          end
        end
      end
      S_CR2: begin
        cmd.sel = hce_pkg::SEL_CR;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_LF2;
        end
      end
      S_LF2: begin
        cmd.sel = hce_pkg::SEL_LF;
        if (status.slot_free) begin
          cmd.load       = 1'b1;
          cmd.last       = !strm_r;
          cmd.fill_clear = 1'b1;
          state_nxt      = strm_r ? S_Z0 : S_IDLE;
        end
      end
      S_Z0: begin
        cmd.sel = hce_pkg::SEL_ZERO;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_ZCR1;
        end
      end
      S_ZCR1: begin
        cmd.sel = hce_pkg::SEL_CR;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_ZLF1;
        end
      end
      S_ZLF1: begin
        cmd.sel = hce_pkg::SEL_LF;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_ZCR2;
        end
      end
      S_ZCR2: begin
        cmd.sel = hce_pkg::SEL_CR;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_ZLF2;
        end
      end
      S_ZLF2: begin
        cmd.sel = hce_pkg::SEL_LF;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      end_r   <= 1'b0;
      strm_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        valid_r <= in_byte_valid;
        end_r   <= in_batch_end || in_stream_end;
        strm_r  <= in_stream_end;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/http_chunked_encoder.sv @@
// Top level of the HTTP/1.1 chunked transfer encoder.
//
//  channel  | ports              | content
//  ---------+--------------------+------------------------------------------
//  input    | in_tvalid/tready   | tdata: data_byte; tuser: byte_valid,
//           |                    | stream_end; tlast: batch_end
//  output   | out_tvalid/tready  | tdata: out_byte; tlast: run_last
//  config   | cfg_we/cfg_wdata   | max_chunk (6 bits)
//
// One request at a time: accept, a decide state, then one encoded byte per
// cycle from the output register (n data bytes give n+5 or n+6 bytes, the
// last chunk 5 more). The output port's one byte per cycle sets the rate.
// out_tready low holds the sequencer; in_tready is high only while idle.
// rst_n (sync, active low) clears the fill count and sets max_chunk to 32;
// the chunk buffer is not cleared.
`default_nettype none
module http_chunked_encoder #(
  parameter int MAX_CHUNK_BYTES = hce_pkg::MAX_CHUNK_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic [1:0] in_tuser,   // [0] byte_valid, [1] stream_end
  input  wire logic       in_tlast,   // batch_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // run_last
);

  hce_pkg::cmd_t    cmd;
  hce_pkg::status_t status;

  hce_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_byte_valid (in_tuser[0]),
    .in_batch_end  (in_tlast),
    .in_stream_end (in_tuser[1]),
    .status        (status),
    .cmd           (cmd)
  );

  hce_datapath #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_data       (in_tdata),
    .in_byte_valid (in_tuser[0]),
    .cmd           (cmd),
    .status        (status),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tready    (out_tready)
  );

endmodule
`default_nettype wire

@@ rtl/hce_checker.sv @@
// Port-level checks for the chunked transfer encoder, bound to the top level.
`default_nettype none
`include "http_chunked_encoder_defines.svh"
module hce_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  logic out_stall;

  assign out_stall = out_tvalid && !out_tready;

  // stalled output holds
  `HCE_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // every run ends on the LF of a chunk trailer
  `HCE_ASSERT_NOW(a_last_is_lf, out_tvalid && out_tlast, out_tdata == hce_pkg::CH_LF)

  // one request in flight
  `HCE_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)

endmodule

bind http_chunked_encoder hce_checker u_hce_checker (.*);
`default_nettype wire
